// ----- sv/xcc_pkg.sv -----
// shared types and constants for the xchacha20 stream cipher unit
// no dependencies
`default_nettype none
package xcc_pkg;

    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    localparam int unsigned ROT_A = 16;
    localparam int unsigned ROT_B = 12;
    localparam int unsigned ROT_C = 8;
    localparam int unsigned ROT_D = 7;

    // 10 double rounds, two half quarter-round steps per round
    localparam int unsigned NUM_STEPS = 40;

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_NONCE0 = 3'd4;
    localparam logic [2:0] REG_NONCE1 = 3'd5;
    localparam logic [2:0] REG_NONCE2 = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HROUND,
        ST_BLOAD,
        ST_BROUND,
        ST_WRITE,
        ST_READ,
        ST_EMIT
    } state_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned r);
        rotl = (v << r) | (v >> (32 - r));
    endfunction

endpackage
`default_nettype wire

// ----- sv/xcc_qr_half.sv -----
// one half of a chacha quarter round: two add, xor, rotate steps
// depends on xcc_pkg
`default_nettype none
module xcc_qr_half (
    input  wire logic        second,
    input  wire logic [31:0] a_in,
    input  wire logic [31:0] b_in,
    input  wire logic [31:0] c_in,
    input  wire logic [31:0] d_in,
    output logic      [31:0] a_out,
    output logic      [31:0] b_out,
    output logic      [31:0] c_out,
    output logic      [31:0] d_out
);
    import xcc_pkg::*;

    always_comb
    begin
        a_out = a_in + b_in;
        d_out = second ? rotl(d_in ^ a_out, ROT_C) : rotl(d_in ^ a_out, ROT_A);
        c_out = c_in + d_out;
        b_out = second ? rotl(b_in ^ c_out, ROT_D) : rotl(b_in ^ c_out, ROT_B);
    end

endmodule
`default_nettype wire

// ----- sv/xcc_ks_mem.sv -----
// keystream block memory, 8 entries of 64 bits, registered read
// no dependencies
`default_nettype none
module xcc_ks_mem (
    input  wire logic        clk,
    input  wire logic        we,
    input  wire logic [2:0]  waddr,
    input  wire logic [63:0] wdata,
    input  wire logic        re,
    input  wire logic [2:0]  raddr,
    output logic      [63:0] rdata
);
    logic [63:0] mem [8];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/xchacha20_stream_cipher_unit.sv -----
// word path: accept, ST_READ, ST_EMIT, output registers; a new block first adds a load,
// 40 round steps and 8 memory writes, and a message start 40 more for subkey derivation
// flow: one word in flight at a time; ST_EMIT waits while the output holds an untaken word;
// rounds run on four half quarter-round units, one step per cycle
// reset: subkey, counter, registers and word position clear at once, no sweep
`default_nettype none
module xchacha20_stream_cipher_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // data_word, byte_count, zero pad
    input  wire logic [0:0]  s_axis_tuser,  // start_message
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [71:0] m_axis_tdata,  // out_word, out_byte_count, zero pad
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);
    import xcc_pkg::*;

    state_t state_reg, state_next;
    logic [63:0] key_reg [4];
    logic [63:0] nonce_reg [3];
    logic [31:0] subkey_reg [8];
    logic [31:0] subkey_next [8];
    logic [63:0] counter_reg, counter_next;
    logic [2:0]  pos_reg, pos_next;
    logic [5:0]  step_reg, step_next;
    logic [2:0]  wcnt_reg, wcnt_next;
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] rnd_w [16];
    logic [31:0] hinit [16];
    logic [31:0] binit [16];
    logic [63:0] data_reg;
    logic [3:0]  cnt_reg;
    logic        last_reg;
    logic        mvalid_reg, mvalid_next;
    logic [63:0] oword_reg;
    logic [3:0]  ocnt_reg;
    logic        olast_reg;
    logic        accept, emit_go, mem_we, mem_re;
    logic [63:0] mem_wdata, mem_rdata, mask;
    logic [3:0]  cnt_sat;
    logic [2:0]  cfg_idx;
    logic        diag;

    assign pready = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata = {4'b0, ocnt_reg, oword_reg};
    assign m_axis_tlast = olast_reg;
    assign diag = step_reg[1];

    always_comb
    begin
        case (cfg_idx)
            REG_KEY0:   prdata = key_reg[0];
            REG_KEY1:   prdata = key_reg[1];
            REG_KEY2:   prdata = key_reg[2];
            REG_KEY3:   prdata = key_reg[3];
            REG_NONCE0: prdata = nonce_reg[0];
            REG_NONCE1: prdata = nonce_reg[1];
            REG_NONCE2: prdata = nonce_reg[2];
            default:    prdata = 64'd0;
        endcase
    end

    always_comb
    begin
        hinit[0] = SIGMA0;
        hinit[1] = SIGMA1;
        hinit[2] = SIGMA2;
        hinit[3] = SIGMA3;
        binit[0] = SIGMA0;
        binit[1] = SIGMA1;
        binit[2] = SIGMA2;
        binit[3] = SIGMA3;
        for (int i = 0; i < 4; i++)
        begin
            hinit[4 + 2 * i] = key_reg[i][31:0];
            hinit[5 + 2 * i] = key_reg[i][63:32];
        end
        for (int i = 0; i < 8; i++)
        begin
            binit[4 + i] = subkey_reg[i];
        end
        hinit[12] = nonce_reg[0][31:0];
        hinit[13] = nonce_reg[0][63:32];
        hinit[14] = nonce_reg[1][31:0];
        hinit[15] = nonce_reg[1][63:32];
        binit[12] = counter_reg[31:0];
        binit[13] = counter_reg[63:32];
        binit[14] = nonce_reg[2][31:0];
        binit[15] = nonce_reg[2][63:32];
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        localparam int unsigned IA = g;
        localparam int unsigned IB_C = 4 + g;
        localparam int unsigned IC_C = 8 + g;
        localparam int unsigned ID_C = 12 + g;
        localparam int unsigned IB_D = 4 + ((g + 1) % 4);
        localparam int unsigned IC_D = 8 + ((g + 2) % 4);
        localparam int unsigned ID_D = 12 + ((g + 3) % 4);
        logic [31:0] a_o, b_o, c_o, d_o;

        xcc_qr_half u_qr (
            .second (step_reg[0]),
            .a_in   (w_reg[IA]),
            .b_in   (diag ? w_reg[IB_D] : w_reg[IB_C]),
            .c_in   (diag ? w_reg[IC_D] : w_reg[IC_C]),
            .d_in   (diag ? w_reg[ID_D] : w_reg[ID_C]),
            .a_out  (a_o),
            .b_out  (b_o),
            .c_out  (c_o),
            .d_out  (d_o)
        );
    end

    // diagonal steps put each lane's b, c, d back at rotated positions
    always_comb
    begin
        rnd_w[0] = g_lane[0].a_o;
        rnd_w[1] = g_lane[1].a_o;
        rnd_w[2] = g_lane[2].a_o;
        rnd_w[3] = g_lane[3].a_o;
        rnd_w[4] = diag ? g_lane[3].b_o : g_lane[0].b_o;
        rnd_w[5] = diag ? g_lane[0].b_o : g_lane[1].b_o;
        rnd_w[6] = diag ? g_lane[1].b_o : g_lane[2].b_o;
        rnd_w[7] = diag ? g_lane[2].b_o : g_lane[3].b_o;
        rnd_w[8] = diag ? g_lane[2].c_o : g_lane[0].c_o;
        rnd_w[9] = diag ? g_lane[3].c_o : g_lane[1].c_o;
        rnd_w[10] = diag ? g_lane[0].c_o : g_lane[2].c_o;
        rnd_w[11] = diag ? g_lane[1].c_o : g_lane[3].c_o;
        rnd_w[12] = diag ? g_lane[1].d_o : g_lane[0].d_o;
        rnd_w[13] = diag ? g_lane[2].d_o : g_lane[1].d_o;
        rnd_w[14] = diag ? g_lane[3].d_o : g_lane[2].d_o;
        rnd_w[15] = diag ? g_lane[0].d_o : g_lane[3].d_o;
    end

    always_comb
    begin
        cnt_sat = (cnt_reg > 4'd8) ? 4'd8 : cnt_reg;
        for (int i = 0; i < 8; i++)
        begin
            mask[8 * i +: 8] = (4'(i) < cnt_sat) ? 8'hff : 8'h00;
        end
        mem_wdata = {w_reg[{wcnt_reg, 1'b1}] + binit[{wcnt_reg, 1'b1}],
                     w_reg[{wcnt_reg, 1'b0}] + binit[{wcnt_reg, 1'b0}]};
    end

    always_comb
    begin
        state_next = state_reg;
        subkey_next = subkey_reg;
        counter_next = counter_reg;
        pos_next = pos_reg;
        step_next = step_reg;
        wcnt_next = wcnt_reg;
        w_next = w_reg;
        mvalid_next = mvalid_reg && !m_axis_tready;
        mem_we = 1'b0;
        mem_re = 1'b0;
        emit_go = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    step_next = 6'd0;
                    if (s_axis_tuser[0])
                    begin
                        w_next = hinit;
                        state_next = ST_HROUND;
                    end
                    else if (pos_reg == 3'd0)
                    begin
                        state_next = ST_BLOAD;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_HROUND:
            begin
                w_next = rnd_w;
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(NUM_STEPS - 1))
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        subkey_next[i] = w_next[i];
                        subkey_next[4 + i] = w_next[12 + i];
                    end
                    counter_next = 64'd0;
                    pos_next = 3'd0;
                    state_next = ST_BLOAD;
                end
                else
                begin
                    state_next = ST_HROUND;
                end
            end
            ST_BLOAD:
            begin
                w_next = binit;
                step_next = 6'd0;
                state_next = ST_BROUND;
            end
            ST_BROUND:
            begin
                w_next = rnd_w;
                step_next = step_reg + 6'd1;
                wcnt_next = 3'd0;
                if (step_reg == 6'(NUM_STEPS - 1))
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
                wcnt_next = wcnt_reg + 3'd1;
                if (wcnt_reg == 3'd7)
                begin
                    counter_next = counter_reg + 64'd1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                mem_re = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!mvalid_reg || m_axis_tready)
                begin
                    emit_go = 1'b1;
                    mvalid_next = 1'b1;
                    pos_next = last_reg ? 3'd0 : pos_reg + 3'd1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            counter_reg <= 64'd0;
            pos_reg <= 3'd0;
            step_reg <= 6'd0;
            wcnt_reg <= 3'd0;
            mvalid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                subkey_reg[i] <= 32'd0;
            for (int i = 0; i < 4; i++)
                key_reg[i] <= 64'd0;
            for (int i = 0; i < 3; i++)
                nonce_reg[i] <= 64'd0;
        end
        else
        begin
            state_reg <= state_next;
            counter_reg <= counter_next;
            pos_reg <= pos_next;
            step_reg <= step_next;
            wcnt_reg <= wcnt_next;
            mvalid_reg <= mvalid_next;
            subkey_reg <= subkey_next;
            if (psel && penable && pwrite && pready)
            begin
                case (cfg_idx)
                    REG_KEY0:   key_reg[0] <= pwdata;
                    REG_KEY1:   key_reg[1] <= pwdata;
                    REG_KEY2:   key_reg[2] <= pwdata;
                    REG_KEY3:   key_reg[3] <= pwdata;
                    REG_NONCE0: nonce_reg[0] <= pwdata;
                    REG_NONCE1: nonce_reg[1] <= pwdata;
                    REG_NONCE2: nonce_reg[2] <= pwdata;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        if (accept)
        begin
            data_reg <= s_axis_tdata[63:0];
            cnt_reg <= s_axis_tdata[67:64];
            last_reg <= s_axis_tlast;
        end
        if (emit_go)
        begin
            oword_reg <= (data_reg ^ mem_rdata) & mask;
            ocnt_reg <= cnt_sat;
            olast_reg <= last_reg;
        end
    end

    xcc_ks_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wcnt_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (pos_reg),
        .rdata (mem_rdata)
    );

`ifndef SYNTHESIS
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !s_axis_tready)
        else $error("input ready while busy");
    a_new_block: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !s_axis_tuser[0] && pos_reg == 3'd0 |=> state_reg == ST_BLOAD)
        else $error("no block made at block start");
    a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE && wcnt_reg == 3'd7 |=>
        counter_reg == $past(counter_reg) + 64'd1)
        else $error("counter did not advance");
`endif

endmodule
`default_nettype wire
